>>> rtl/core/ils_pkg.sv
// shared types and constants of the indexed list store
package ils_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int ENTRY_WIDTH_DEF = 32;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int ELEM_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_INSERT_AT  = 3'd4,
    CMD_EXTRACT_AT = 3'd5,
    CMD_READ_NTH   = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    K_ERR     = 2'd0,
    K_INSERT  = 2'd1,
    K_EXTRACT = 2'd2,
    K_READ    = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    RD_REQ  = 2'd0,
    RD_NEXT = 2'd1,
    RD_PREV = 2'd2,
    RD_LAST = 2'd3
  } rd_src_t;

  typedef enum logic [1:0] {
    WR_PLACE = 2'd0,
    WR_DOWN  = 2'd1,
    WR_UP    = 2'd2
  } wr_src_t;

  typedef struct packed {
    logic    accept;
    logic    rd_en;
    rd_src_t rd_src;
    logic    wr_en;
    wr_src_t wr_src;
    logic    cap;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit;
  } dp_cmd_t;

  typedef struct packed {
    req_kind_t kind;
    logic      at_end;
    logic      more_down;
    logic      more_up;
    logic      slot_free;
  } dp_stat_t;

endpackage

>>> rtl/core/ils_if.sv
// request and response channel interfaces of the indexed list store
interface ils_req_if;
  logic                       valid;
  logic                       ready;
  logic [ils_pkg::CMD_W-1:0]  cmd;
  logic [ils_pkg::POS_W-1:0]  position;
  logic [ils_pkg::ELEM_W-1:0] element_in;

  modport source (output valid, output cmd, output position, output element_in, input ready);
  modport sink (input valid, input cmd, input position, input element_in, output ready);
endinterface

interface ils_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ils_pkg::ELEM_W-1:0]   element_out;
  logic [ils_pkg::STATUS_W-1:0] status;
  logic                         nonempty_after;
  logic [ils_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, output element_out, output status, output nonempty_after,
                  output entry_count, input ready);
  modport sink (input valid, input element_out, input status, input nonempty_after,
                input entry_count, output ready);
endinterface

>>> rtl/core/ils_ram.sv
// generic simple dual-port ram with registered read
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/ils_ctrl.sv
// sequencing state machine of the indexed list store
module ils_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ils_pkg::dp_stat_t stat,
  output ils_pkg::dp_cmd_t  ctl
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RCAP  = 7'b0000010,
    S_XCAP  = 7'b0000100,
    S_DOWN  = 7'b0001000,
    S_UP    = 7'b0010000,
    S_PLACE = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ctl         = '0;
    ctl.rd_src  = ils_pkg::RD_REQ;
    ctl.wr_src  = ils_pkg::WR_PLACE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          case (stat.kind)
            ils_pkg::K_READ: begin
              ctl.rd_en  = 1'b1;
              state_next = S_RCAP;
            end
            ils_pkg::K_EXTRACT: begin
              ctl.rd_en  = 1'b1;
              state_next = S_XCAP;
            end
            ils_pkg::K_INSERT: begin
              if (stat.at_end) begin
                state_next = S_PLACE;
              end else begin
                ctl.rd_en  = 1'b1;
                ctl.rd_src = ils_pkg::RD_LAST;
                state_next = S_UP;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_RCAP: begin
        ctl.cap    = 1'b1;
        state_next = S_DONE;
      end
      S_XCAP: begin
        ctl.cap = 1'b1;
        if (stat.more_down) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_src = ils_pkg::RD_NEXT;
          state_next = S_DOWN;
        end else begin
          ctl.cnt_dec = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DOWN: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_src = ils_pkg::WR_DOWN;
        if (stat.more_down) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_src = ils_pkg::RD_NEXT;
        end else begin
          ctl.cnt_dec = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_UP: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_src = ils_pkg::WR_UP;
        if (stat.more_up) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_src = ils_pkg::RD_PREV;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_src  = ils_pkg::WR_PLACE;
        ctl.cnt_inc = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (stat.slot_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/ils_datapath.sv
// request decode, entry store, shift pointers and response register
module ils_datapath #(
  parameter int CAPACITY    = ils_pkg::CAPACITY_DEF,
  parameter int ENTRY_WIDTH = ils_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [ils_pkg::CMD_W-1:0]      cmd,
  input  logic [ils_pkg::POS_W-1:0]      position,
  input  logic [ils_pkg::ELEM_W-1:0]     element_in,
  input  ils_pkg::dp_cmd_t               ctl,
  output ils_pkg::dp_stat_t              stat,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [ils_pkg::ELEM_W-1:0]     element_out,
  output logic [ils_pkg::STATUS_W-1:0]   status,
  output logic                           nonempty_after,
  output logic [ils_pkg::COUNT_W-1:0]    entry_count
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W;

  logic [CW-1:0]          count;
  logic [AW-1:0]          rptr;
  logic [AW-1:0]          tgt;
  logic [ENTRY_WIDTH-1:0] elem;
  logic [ENTRY_WIDTH-1:0] res_elem;
  ils_pkg::status_t       res_status;

  logic [CMPW-1:0]        pos_x;
  logic [CMPW-1:0]        cnt_x;
  logic                   full;
  logic                   empty;
  ils_pkg::status_t       req_status;
  ils_pkg::req_kind_t     req_kind;
  logic [AW-1:0]          req_addr;

  logic [ENTRY_WIDTH+ils_pkg::ELEM_W-1:0] in_ext;
  logic [ENTRY_WIDTH+ils_pkg::ELEM_W-1:0] out_ext;
  logic [ENTRY_WIDTH-1:0] in_entry;

  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic [ENTRY_WIDTH-1:0] wr_data;
  logic [ENTRY_WIDTH-1:0] rd_data;

  assign full     = (count == CW'(CAPACITY));
  assign empty    = (count == '0);
  assign pos_x    = CMPW'(position);
  assign cnt_x    = CMPW'(count);
  assign in_ext   = {{ENTRY_WIDTH{1'b0}}, element_in};
  assign in_entry = in_ext[ENTRY_WIDTH-1:0];
  assign out_ext  = {{ils_pkg::ELEM_W{1'b0}}, res_elem};

  always_comb begin
    req_status = ils_pkg::ST_OK;
    req_kind   = ils_pkg::K_ERR;
    req_addr   = AW'(position);
    case (ils_pkg::cmd_t'(cmd))
      ils_pkg::CMD_PUSH_BACK, ils_pkg::CMD_PUSH_FRONT: begin
        req_addr = (ils_pkg::cmd_t'(cmd) == ils_pkg::CMD_PUSH_BACK) ? AW'(count) : '0;
        if (full) begin
          req_status = ils_pkg::ST_FULL;
        end else begin
          req_kind = ils_pkg::K_INSERT;
        end
      end
      ils_pkg::CMD_POP_BACK, ils_pkg::CMD_POP_FRONT: begin
        req_addr = (ils_pkg::cmd_t'(cmd) == ils_pkg::CMD_POP_BACK) ?
                   AW'(count - CW'(1)) : '0;
        if (empty) begin
          req_status = ils_pkg::ST_RANGE;
        end else begin
          req_kind = ils_pkg::K_EXTRACT;
        end
      end
      ils_pkg::CMD_INSERT_AT: begin
        if (pos_x > cnt_x) begin
          req_status = ils_pkg::ST_RANGE;
        end else if (full) begin
          req_status = ils_pkg::ST_FULL;
        end else begin
          req_kind = ils_pkg::K_INSERT;
        end
      end
      ils_pkg::CMD_EXTRACT_AT: begin
        if (pos_x >= cnt_x) begin
          req_status = ils_pkg::ST_RANGE;
        end else begin
          req_kind = ils_pkg::K_EXTRACT;
        end
      end
      ils_pkg::CMD_READ_NTH: begin
        if (pos_x >= cnt_x) begin
          req_status = ils_pkg::ST_RANGE;
        end else begin
          req_kind = ils_pkg::K_READ;
        end
      end
      default: begin
        req_status = ils_pkg::ST_RANGE;
      end
    endcase
  end

  always_comb begin
    stat.kind      = req_kind;
    stat.at_end    = (CMPW'(req_addr) == cnt_x);
    stat.more_down = ((CW'(rptr) + CW'(1)) < count);
    stat.more_up   = (rptr > tgt);
    stat.slot_free = !out_valid || out_ready;
  end

  always_comb begin
    case (ctl.rd_src)
      ils_pkg::RD_REQ:  rd_addr = req_addr;
      ils_pkg::RD_NEXT: rd_addr = rptr + AW'(1);
      ils_pkg::RD_PREV: rd_addr = rptr - AW'(1);
      ils_pkg::RD_LAST: rd_addr = AW'(count - CW'(1));
      default:          rd_addr = req_addr;
    endcase
  end

  always_comb begin
    case (ctl.wr_src)
      ils_pkg::WR_DOWN: begin
        wr_addr = rptr - AW'(1);
        wr_data = rd_data;
      end
      ils_pkg::WR_UP: begin
        wr_addr = rptr + AW'(1);
        wr_data = rd_data;
      end
      default: begin
        wr_addr = tgt;
        wr_data = elem;
      end
    endcase
  end

  ils_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (ctl.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.cnt_inc) begin
        count <= count + CW'(1);
      end else if (ctl.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (ctl.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      tgt        <= req_addr;
      elem       <= in_entry;
      res_status <= req_status;
      res_elem   <= '0;
    end
    if (ctl.rd_en) begin
      rptr <= rd_addr;
    end
    if (ctl.cap) begin
      res_elem <= rd_data;
    end
    if (ctl.emit) begin
      element_out    <= out_ext[ils_pkg::ELEM_W-1:0];
      status         <= res_status;
      nonempty_after <= (count != '0);
      entry_count    <= ils_pkg::COUNT_W'(count);
    end
  end

endmodule

>>> rtl/core/indexed_list_store_unit.sv
// top level of the indexed list store: controller, datapath and entry ram
// steps: a rejected request goes straight to the result; read_nth reads the entry;
// insert at p shifts entries p to last up, then writes the new one; removal at p
// reads the entry, then shifts the ones above it down, each through the single ram
// read and write port; the next request is taken after the result is loaded
// reset: synchronous; empties the list and the response register, ram not cleared
module indexed_list_store_unit #(
  parameter int CAPACITY    = ils_pkg::CAPACITY_DEF,
  parameter int ENTRY_WIDTH = ils_pkg::ENTRY_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  ils_req_if.sink   req,
  ils_rsp_if.source rsp
);

  ils_pkg::dp_cmd_t  ctl;
  ils_pkg::dp_stat_t stat;
  logic              in_ready;

  assign req.ready = in_ready;

  ils_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  ils_datapath #(
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (req.cmd),
    .position       (req.position),
    .element_in     (req.element_in),
    .ctl            (ctl),
    .stat           (stat),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .element_out    (rsp.element_out),
    .status         (rsp.status),
    .nonempty_after (rsp.nonempty_after),
    .entry_count    (rsp.entry_count)
  );

endmodule

>>> rtl/core/ils_checker.sv
// port-level assertions of the indexed list store and their bind
module ils_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [ils_pkg::ELEM_W-1:0]   element_out,
  input logic [ils_pkg::STATUS_W-1:0] status,
  input logic                         nonempty_after,
  input logic [ils_pkg::COUNT_W-1:0]  entry_count
);

  // stalled transaction keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(element_out) && $stable(status)
      && $stable(nonempty_after) && $stable(entry_count))
    else $error("response changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ils_pkg::ST_OK) |-> (element_out == '0))
    else $error("failed request returned an entry");

  a_full_nonempty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ils_pkg::ST_FULL) |-> nonempty_after)
    else $error("full status with empty list");

  // ready drops in the cycle after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken in back-to-back cycles");

endmodule

bind indexed_list_store_unit ils_checker u_ils_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .element_out    (rsp.element_out),
  .status         (rsp.status),
  .nonempty_after (rsp.nonempty_after),
  .entry_count    (rsp.entry_count)
);
